/* rtl/acsc_pkg.sv */
`default_nettype none

package acsc_pkg;

    // Reset value of the contact skin register
    localparam logic [3:0] EDGE_TOL_RESET = 4'd2;

    // Contact side codes
    localparam logic [2:0] SIDE_NONE   = 3'd0;
    localparam logic [2:0] SIDE_LEFT   = 3'd1;
    localparam logic [2:0] SIDE_RIGHT  = 3'd2;
    localparam logic [2:0] SIDE_TOP    = 3'd3;
    localparam logic [2:0] SIDE_BOTTOM = 3'd4;

    // Distance kind codes
    localparam logic [1:0] KIND_NONE     = 2'd0;
    localparam logic [1:0] KIND_PLATFORM = 2'd1;
    localparam logic [1:0] KIND_CEILING  = 2'd2;

    // Input item: one rectangle pair
    typedef struct packed {
        logic signed [15:0] moving_x;
        logic signed [15:0] moving_y;
        logic        [11:0] moving_w;
        logic        [11:0] moving_h;
        logic signed [15:0] target_x;
        logic signed [15:0] target_y;
        logic        [11:0] target_w;
        logic        [11:0] target_h;
        logic               mover_hits_ceiling;
    } t_in;

    // Result item
    typedef struct packed {
        logic [2:0]  contact_side;
        logic [1:0]  distance_kind;
        logic [15:0] vertical_distance;
    } t_out;

    // Stage 1: edges, centers and half sizes
    typedef struct packed {
        logic signed [15:0] mx;
        logic signed [15:0] my;
        logic signed [15:0] tx;
        logic signed [15:0] ty;
        logic signed [16:0] m_r;
        logic signed [16:0] m_b;
        logic signed [16:0] t_r;
        logic signed [16:0] t_b;
        logic signed [16:0] cmx;
        logic signed [16:0] cmy;
        logic signed [16:0] ctx;
        logic signed [16:0] cty;
        logic        [11:0] hx;
        logic        [11:0] hy;
        logic               ceil_ok;
        logic        [3:0]  skin;
    } t_s1;

    // Stage 2: gaps, overlaps and center deltas
    typedef struct packed {
        logic               hov;
        logic               vov;
        logic signed [17:0] g_floor;
        logic signed [17:0] g_ceil;
        logic signed [17:0] g_rwall;
        logic signed [17:0] g_lwall;
        logic signed [17:0] dx;
        logic signed [17:0] dy;
        logic        [11:0] hx;
        logic        [11:0] hy;
        logic               ceil_ok;
        logic        [3:0]  skin;
    } t_s2;

    // Stage 3: edge contact flags, penetrations and distance
    typedef struct packed {
        logic               hit_floor;
        logic               hit_ceil;
        logic               hit_rwall;
        logic               hit_lwall;
        logic signed [17:0] ox;
        logic signed [17:0] oy;
        logic               dx_neg;
        logic               dy_neg;
        logic        [1:0]  kind;
        logic        [15:0] gap_px;
    } t_s3;

endpackage

`default_nettype wire

/* rtl/acsc_prep.sv */
`default_nettype none

module acsc_prep (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire acsc_pkg::t_in   i_item,
    input  wire logic [3:0]      i_skin,
    output logic                 o_valid,
    output acsc_pkg::t_s1        o_data
);

    logic          r_valid;
    acsc_pkg::t_s1 r_data;
    acsc_pkg::t_s1 n_data;

    // Form far edges, centers and combined half sizes
    always_comb begin
        n_data.mx      = i_item.moving_x;
        n_data.my      = i_item.moving_y;
        n_data.tx      = i_item.target_x;
        n_data.ty      = i_item.target_y;
        n_data.m_r     = {i_item.moving_x[15], i_item.moving_x} + {5'b0, i_item.moving_w};
        n_data.m_b     = {i_item.moving_y[15], i_item.moving_y} + {5'b0, i_item.moving_h};
        n_data.t_r     = {i_item.target_x[15], i_item.target_x} + {5'b0, i_item.target_w};
        n_data.t_b     = {i_item.target_y[15], i_item.target_y} + {5'b0, i_item.target_h};
        n_data.cmx     = {i_item.moving_x[15], i_item.moving_x}
                       + {6'b0, i_item.moving_w[11:1]};
        n_data.cmy     = {i_item.moving_y[15], i_item.moving_y}
                       + {6'b0, i_item.moving_h[11:1]};
        n_data.ctx     = {i_item.target_x[15], i_item.target_x}
                       + {6'b0, i_item.target_w[11:1]};
        n_data.cty     = {i_item.target_y[15], i_item.target_y}
                       + {6'b0, i_item.target_h[11:1]};
        n_data.hx      = 12'(({1'b0, i_item.moving_w} + {1'b0, i_item.target_w}) >> 1);
        n_data.hy      = 12'(({1'b0, i_item.moving_h} + {1'b0, i_item.target_h}) >> 1);
        n_data.ceil_ok = i_item.mover_hits_ceiling;
        n_data.skin    = i_skin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

/* rtl/acsc_gap.sv */
`default_nettype none

module acsc_gap (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire acsc_pkg::t_s1   i_data,
    output logic                 o_valid,
    output acsc_pkg::t_s2        o_data
);

    logic          r_valid;
    acsc_pkg::t_s2 r_data;
    acsc_pkg::t_s2 n_data;
    logic signed [16:0] mx_e;
    logic signed [16:0] my_e;
    logic signed [16:0] tx_e;
    logic signed [16:0] ty_e;

    // Strict overlap tests, edge gaps and center deltas
    always_comb begin
        mx_e = {i_data.mx[15], i_data.mx};
        my_e = {i_data.my[15], i_data.my};
        tx_e = {i_data.tx[15], i_data.tx};
        ty_e = {i_data.ty[15], i_data.ty};

        n_data.hov     = (mx_e < i_data.t_r) && (i_data.m_r > tx_e);
        n_data.vov     = (my_e < i_data.t_b) && (i_data.m_b > ty_e);
        n_data.g_floor = {ty_e[16], ty_e} - {i_data.m_b[16], i_data.m_b};
        n_data.g_ceil  = {my_e[16], my_e} - {i_data.t_b[16], i_data.t_b};
        n_data.g_rwall = {tx_e[16], tx_e} - {i_data.m_r[16], i_data.m_r};
        n_data.g_lwall = {mx_e[16], mx_e} - {i_data.t_r[16], i_data.t_r};
        n_data.dx      = {i_data.cmx[16], i_data.cmx} - {i_data.ctx[16], i_data.ctx};
        n_data.dy      = {i_data.cmy[16], i_data.cmy} - {i_data.cty[16], i_data.cty};
        n_data.hx      = i_data.hx;
        n_data.hy      = i_data.hy;
        n_data.ceil_ok = i_data.ceil_ok;
        n_data.skin    = i_data.skin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

/* rtl/acsc_classify.sv */
`default_nettype none

module acsc_classify (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire acsc_pkg::t_s2   i_data,
    output logic                 o_valid,
    output acsc_pkg::t_out       o_result
);

    logic               r_valid3;
    acsc_pkg::t_s3      r_s3;
    acsc_pkg::t_s3      n_s3;
    logic               r_valid4;
    acsc_pkg::t_out     r_out;
    acsc_pkg::t_out     n_out;
    logic signed [17:0] skin_pos;
    logic signed [17:0] skin_neg;
    logic signed [17:0] abs_dx;
    logic signed [17:0] abs_dy;
    logic               in_floor;
    logic               in_ceil;
    logic               in_rwall;
    logic               in_lwall;

    // Stage 3: skin window tests, penetration depths, vertical distance
    always_comb begin
        skin_pos = {14'b0, i_data.skin};
        skin_neg = -skin_pos;
        in_floor = (i_data.g_floor >= skin_neg) && (i_data.g_floor <= skin_pos);
        in_ceil  = (i_data.g_ceil  >= skin_neg) && (i_data.g_ceil  <= skin_pos);
        in_rwall = (i_data.g_rwall >= skin_neg) && (i_data.g_rwall <= skin_pos);
        in_lwall = (i_data.g_lwall >= skin_neg) && (i_data.g_lwall <= skin_pos);
        abs_dx   = i_data.dx[17] ? -i_data.dx : i_data.dx;
        abs_dy   = i_data.dy[17] ? -i_data.dy : i_data.dy;

        n_s3.hit_floor = i_data.hov && in_floor;
        n_s3.hit_ceil  = i_data.hov && in_ceil;
        n_s3.hit_rwall = i_data.vov && in_rwall;
        n_s3.hit_lwall = i_data.vov && in_lwall;
        n_s3.ox        = {6'b0, i_data.hx} - abs_dx;
        n_s3.oy        = {6'b0, i_data.hy} - abs_dy;
        n_s3.dx_neg    = i_data.dx[17];
        n_s3.dy_neg    = i_data.dy[17];

        // Gaps of a reported kind lie in 0..65535; clamp anything above
        n_s3.kind   = acsc_pkg::KIND_NONE;
        n_s3.gap_px = 16'd0;
        if (i_data.hov && !i_data.g_floor[17]) begin
            n_s3.kind   = acsc_pkg::KIND_PLATFORM;
            n_s3.gap_px = i_data.g_floor[16] ? 16'hFFFF : i_data.g_floor[15:0];
        end else if (i_data.hov && i_data.ceil_ok && !i_data.g_ceil[17]) begin
            n_s3.kind   = acsc_pkg::KIND_CEILING;
            n_s3.gap_px = i_data.g_ceil[16] ? 16'hFFFF : i_data.g_ceil[15:0];
        end
    end

    // Stage 4: priority pick of the contact side
    always_comb begin
        n_out.distance_kind     = r_s3.kind;
        n_out.vertical_distance = r_s3.gap_px;
        if (r_s3.hit_floor) begin
            n_out.contact_side = acsc_pkg::SIDE_BOTTOM;
        end else if (r_s3.hit_ceil) begin
            n_out.contact_side = acsc_pkg::SIDE_TOP;
        end else if (r_s3.hit_rwall) begin
            n_out.contact_side = acsc_pkg::SIDE_LEFT;
        end else if (r_s3.hit_lwall) begin
            n_out.contact_side = acsc_pkg::SIDE_RIGHT;
        end else if ((r_s3.ox <= 18'sd0) || (r_s3.oy <= 18'sd0)) begin
            n_out.contact_side = acsc_pkg::SIDE_NONE;
        end else if (r_s3.ox < r_s3.oy) begin
            n_out.contact_side = r_s3.dx_neg ? acsc_pkg::SIDE_LEFT : acsc_pkg::SIDE_RIGHT;
        end else begin
            n_out.contact_side = r_s3.dy_neg ? acsc_pkg::SIDE_BOTTOM : acsc_pkg::SIDE_TOP;
        end
    end

    // Advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid3 <= 1'b0;
            r_valid4 <= 1'b0;
        end else begin
            r_valid3 <= i_valid;
            r_valid4 <= r_valid3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3  <= n_s3;
        r_out <= n_out;
    end

    assign o_valid  = r_valid4;
    assign o_result = r_out;

endmodule

`default_nettype wire

/* rtl/aabb_contact_side_classifier_core.sv */
`default_nettype none

// Contact-side classifier for a moving and a target axis-aligned rectangle.
// A pair is taken on any cycle with start high and busy low; busy is high
// while reset holds the block and until r_skin is set after reset ends,
// then stays low, so a pair can be issued every cycle.
// Each pair yields exactly one result, strobed by o_valid for one cycle
// in issue order. The result passes through the four register stages:
// edge/center sums, gaps and overlaps, skin window and penetration
// depths, then the priority pick of the side.
// The receiver cannot stall, so o_result must be captured on the strobe.
// The skin register is written through i_cfg_we/i_cfg_wdata; write it only
// while no result is outstanding.

module aabb_contact_side_classifier_core (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire acsc_pkg::t_in   i_item,
    input  wire logic            i_cfg_we,
    input  wire logic [3:0]      i_cfg_wdata,
    output logic                 o_valid,
    output acsc_pkg::t_out       o_result
);

    logic          r_skin;
    logic [3:0]    r_edge_tol;
    logic          accept;
    logic          v1;
    acsc_pkg::t_s1 s1;
    logic          v2;
    acsc_pkg::t_s2 s2;

    // Hold the skin register; mark the block live once out of reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_tol <= acsc_pkg::EDGE_TOL_RESET;
            r_skin     <= 1'b0;
        end else begin
            r_skin <= 1'b1;
            if (i_cfg_we) begin
                r_edge_tol <= i_cfg_wdata;
            end
        end
    end

    assign busy   = !r_skin;
    assign accept = start && !busy;

    acsc_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_item  (i_item),
        .i_skin  (r_edge_tol),
        .o_valid (v1),
        .o_data  (s1)
    );

    acsc_gap u_gap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v1),
        .i_data  (s1),
        .o_valid (v2),
        .o_data  (s2)
    );

    acsc_classify u_classify (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (v2),
        .i_data   (s2),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    // Every transfer is followed by its result strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##4 o_valid)
        else $error("result strobe missing four cycles after transfer");

    // No strobe without a matching earlier transfer
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, 4))
        else $error("result strobe without matching transfer");

    // No distance kind means zero distance
    a_zero_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result.distance_kind == acsc_pkg::KIND_NONE))
        |-> (o_result.vertical_distance == 16'd0))
        else $error("distance reported without a kind");

    // Side and kind stay within their codes
    a_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_result.contact_side <= acsc_pkg::SIDE_BOTTOM)
                 && (o_result.distance_kind <= acsc_pkg::KIND_CEILING)))
        else $error("result code out of range");

endmodule

`default_nettype wire
